FILE: rtl/segment_circle_collision_defines.svh
// assertion macros shared by the checker of segment_circle_collision
// no dependencies; the including module supplies clk and rst
`ifndef SEGMENT_CIRCLE_COLLISION_DEFINES_SVH
`define SEGMENT_CIRCLE_COLLISION_DEFINES_SVH

// same-cycle implication, off while reset is high
`define SCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment_circle_collision check failed");

// next-cycle consequence of reset, evaluated during reset too
`define SCC_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("segment_circle_collision reset check failed");

`endif

FILE: rtl/scc_pkg.sv
// shared constants of the segment / circle collision block
// no dependencies
package scc_pkg;

  parameter int SCC_COORD_BITS = 16;
  parameter int SCC_FRAC_BITS  = 16;

endpackage

FILE: rtl/segment_circle_collision.sv
// segment / circle collision test, fully pipelined
// done follows the accepting edge through stages 1 to 4, the bit-per-stage divider
// forming t, and stages 5 to 11
// throughput: one item per cycle, busy is low except during reset
// reset: synchronous rst clears every valid bit; items in flight are lost to the receiver
// depends on scc_pkg and scc_div
module segment_circle_collision
  import scc_pkg::*;
#(
  parameter int COORD_BITS      = SCC_COORD_BITS,
  parameter int PARAM_FRAC_BITS = SCC_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic        [COORD_BITS-2:0] circle_radius,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         done,
  output logic                         hit,
  output logic signed [COORD_BITS:0]   normal_x,
  output logic signed [COORD_BITS:0]   normal_y,
  output logic                         closest_valid,
  output logic signed [COORD_BITS-1:0] closest_x,
  output logic signed [COORD_BITS-1:0] closest_y
);

  localparam int C   = COORD_BITS;
  localparam int F   = PARAM_FRAC_BITS;
  localparam int DW  = C + 1;          // coordinate difference
  localparam int PRW = 2 * DW;         // product of two differences
  localparam int SW  = 2 * C + 3;      // sums of products
  localparam int LW  = 2 * C + 1;      // squared segment length
  localparam int RW  = 2 * C - 2;      // squared radius
  localparam int MW  = 2 * C + 1;      // |dot|
  localparam int NW  = 2 * C + F + 2; // rounded divider numerator
  localparam int QW  = F + C + 3;      // quotient bits
  localparam int TW  = QW + 1;         // signed t
  localparam int MPW = TW + DW;        // t times delta
  localparam int RSW = MPW + 1;
  localparam int SHW = RSW - F;
  localparam int OFW = SHW + 1;
  localparam int XW  = OFW + 1;

  localparam logic [QW-1:0]         TLIM = QW'(1) << (F + C + 2);
  localparam logic [RSW-1:0]        HALF = RSW'(1) << (F - 1);
  localparam logic signed [C-1:0]   CMIN = {1'b1, {(C-1){1'b0}}};
  localparam logic signed [C-1:0]   CMAX = {1'b0, {(C-1){1'b1}}};

  // item context carried alongside the division
  typedef struct packed {
    logic signed [C-1:0]  cx;
    logic signed [C-1:0]  cy;
    logic signed [C-1:0]  x1;
    logic signed [C-1:0]  y1;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic        [RW-1:0] r2;
    logic                 ep;     // an endpoint lies inside the circle
    logic signed [DW-1:0] nxe;
    logic signed [DW-1:0] nye;
    logic                 proj;   // projection path taken
    logic                 t_rng;  // 0 <= dot <= len2
    logic                 neg;    // dot below zero
  } carry_t;

  localparam int TAGW = $bits(carry_t);

  assign busy = rst;

  // stage 1: differences
  logic                 s1_v;
  logic signed [DW-1:0] s1_ax, s1_ay, s1_bx, s1_by, s1_dx, s1_dy;
  logic signed [C-1:0]  s1_cx, s1_cy, s1_x1, s1_y1;
  logic        [C-2:0]  s1_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start;
    end
    s1_ax <= DW'(center_x) - DW'(start_x);
    s1_ay <= DW'(center_y) - DW'(start_y);
    s1_bx <= DW'(center_x) - DW'(end_x);
    s1_by <= DW'(center_y) - DW'(end_y);
    s1_dx <= DW'(end_x) - DW'(start_x);
    s1_dy <= DW'(end_y) - DW'(start_y);
    s1_cx <= center_x;
    s1_cy <= center_y;
    s1_x1 <= start_x;
    s1_y1 <= start_y;
    s1_r  <= circle_radius;
  end

  // stage 2: squares and dot-product terms
  logic                  s2_v;
  logic signed [PRW-1:0] s2_ax2, s2_ay2, s2_bx2, s2_by2, s2_dx2, s2_dy2, s2_pdx, s2_pdy;
  logic        [RW-1:0]  s2_r2;
  logic signed [DW-1:0]  s2_ax, s2_ay, s2_bx, s2_by, s2_dx, s2_dy;
  logic signed [C-1:0]   s2_cx, s2_cy, s2_x1, s2_y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_ax2 <= s1_ax * s1_ax;
    s2_ay2 <= s1_ay * s1_ay;
    s2_bx2 <= s1_bx * s1_bx;
    s2_by2 <= s1_by * s1_by;
    s2_dx2 <= s1_dx * s1_dx;
    s2_dy2 <= s1_dy * s1_dy;
    s2_pdx <= s1_ax * s1_dx;
    s2_pdy <= s1_ay * s1_dy;
    s2_r2  <= RW'(s1_r) * RW'(s1_r);
    s2_ax  <= s1_ax;
    s2_ay  <= s1_ay;
    s2_bx  <= s1_bx;
    s2_by  <= s1_by;
    s2_dx  <= s1_dx;
    s2_dy  <= s1_dy;
    s2_cx  <= s1_cx;
    s2_cy  <= s1_cy;
    s2_x1  <= s1_x1;
    s2_y1  <= s1_y1;
  end

  // stage 3: sums
  logic                 s3_v;
  logic signed [SW-1:0] s3_da, s3_db, s3_dot;
  logic        [LW-1:0] s3_len2;
  logic        [RW-1:0] s3_r2;
  logic signed [DW-1:0] s3_ax, s3_ay, s3_bx, s3_by, s3_dx, s3_dy;
  logic signed [C-1:0]  s3_cx, s3_cy, s3_x1, s3_y1;
  logic signed [SW-1:0] len_sum;

  assign len_sum = SW'(s2_dx2) + SW'(s2_dy2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_da   <= SW'(s2_ax2) + SW'(s2_ay2);
    s3_db   <= SW'(s2_bx2) + SW'(s2_by2);
    s3_dot  <= SW'(s2_pdx) + SW'(s2_pdy);
    s3_len2 <= len_sum[LW-1:0];
    s3_r2   <= s2_r2;
    s3_ax   <= s2_ax;
    s3_ay   <= s2_ay;
    s3_bx   <= s2_bx;
    s3_by   <= s2_by;
    s3_dx   <= s2_dx;
    s3_dy   <= s2_dy;
    s3_cx   <= s2_cx;
    s3_cy   <= s2_cy;
    s3_x1   <= s2_x1;
    s3_y1   <= s2_y1;
  end

  // stage 4: endpoint tests, case decision, divider operands
  logic signed [SW-1:0] r2_s, len2_s;
  logic                 ep_a, ep_b;
  logic        [SW-1:0] dot_abs;
  logic        [NW-1:0] num_c;
  carry_t               tag_c;

  assign r2_s    = $signed(SW'(s3_r2));
  assign len2_s  = $signed(SW'(s3_len2));
  assign ep_a    = (s3_da <= r2_s);
  assign ep_b    = (s3_db <= r2_s);
  assign dot_abs = s3_dot[SW-1] ? SW'(-s3_dot) : SW'(s3_dot);
  // round to nearest by adding half the divisor up front
  assign num_c   = (NW'(dot_abs[MW-1:0]) << F) + NW'(s3_len2 >> 1);

  always_comb begin
    tag_c       = '0;
    tag_c.cx    = s3_cx;
    tag_c.cy    = s3_cy;
    tag_c.x1    = s3_x1;
    tag_c.y1    = s3_y1;
    tag_c.dx    = s3_dx;
    tag_c.dy    = s3_dy;
    tag_c.r2    = s3_r2;
    tag_c.ep    = ep_a || ep_b;
    tag_c.nxe   = ep_a ? s3_ax : s3_bx;
    tag_c.nye   = ep_a ? s3_ay : s3_by;
    tag_c.proj  = (s3_len2 != '0);
    tag_c.t_rng = !s3_dot[SW-1] && (s3_dot <= len2_s);
    tag_c.neg   = s3_dot[SW-1];
  end

  logic            s4_v;
  logic [NW-1:0]   s4_num;
  logic [LW-1:0]   s4_den;
  carry_t          s4_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else begin
      s4_v <= s3_v;
    end
    s4_num <= num_c;
    s4_den <= s3_len2;
    s4_tag <= tag_c;
  end

  // divider: t magnitude = round(|dot| * 2^F / len2)
  logic            d_v;
  logic [QW-1:0]   d_q;
  logic            d_sat;
  logic [TAGW-1:0] d_tag_bits;
  carry_t          d_tag;

  scc_div #(
    .NUM_BITS (NW),
    .DEN_BITS (LW),
    .QUO_BITS (QW),
    .TAG_BITS (TAGW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_v),
    .num       (s4_num),
    .den       (s4_den),
    .in_tag    (s4_tag),
    .out_valid (d_v),
    .quo       (d_q),
    .sat       (d_sat),
    .out_tag   (d_tag_bits)
  );

  assign d_tag = carry_t'(d_tag_bits);

  // stage 5: clamp and sign t
  logic [QW-1:0]        qc;
  logic                 s5_v;
  logic signed [TW-1:0] s5_t;
  carry_t               s5_tag;

  assign qc = (d_sat || (d_q > TLIM)) ? TLIM : d_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else begin
      s5_v <= d_v;
    end
    s5_t   <= d_tag.neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    s5_tag <= d_tag;
  end

  // stage 6: t times delta
  logic                  s6_v;
  logic signed [MPW-1:0] s6_px, s6_py;
  carry_t                s6_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else begin
      s6_v <= s5_v;
    end
    s6_px  <= MPW'(s5_t) * MPW'(s5_tag.dx);
    s6_py  <= MPW'(s5_t) * MPW'(s5_tag.dy);
    s6_tag <= s5_tag;
  end

  // stage 7: drop fraction, round half away from zero
  logic [MPW-1:0]       mag_x, mag_y;
  logic [RSW-1:0]       rs_x, rs_y;
  logic [SHW-1:0]       sh_x, sh_y;
  logic                 s7_v;
  logic signed [OFW-1:0] s7_ox, s7_oy;
  carry_t               s7_tag;

  assign mag_x = s6_px[MPW-1] ? MPW'(-s6_px) : MPW'(s6_px);
  assign mag_y = s6_py[MPW-1] ? MPW'(-s6_py) : MPW'(s6_py);
  assign rs_x  = RSW'(mag_x) + HALF;
  assign rs_y  = RSW'(mag_y) + HALF;
  assign sh_x  = SHW'(rs_x >> F);
  assign sh_y  = SHW'(rs_y >> F);

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else begin
      s7_v <= s6_v;
    end
    s7_ox  <= s6_px[MPW-1] ? -$signed({1'b0, sh_x}) : $signed({1'b0, sh_x});
    s7_oy  <= s6_py[MPW-1] ? -$signed({1'b0, sh_y}) : $signed({1'b0, sh_y});
    s7_tag <= s6_tag;
  end

  // stage 8: closest point, saturated to the coordinate range
  logic signed [XW-1:0] xs, ys;
  logic signed [C-1:0]  px_c, py_c;
  logic                 s8_v;
  logic signed [C-1:0]  s8_px, s8_py;
  carry_t               s8_tag;

  assign xs = XW'(s7_ox) + XW'(s7_tag.x1);
  assign ys = XW'(s7_oy) + XW'(s7_tag.y1);

  always_comb begin
    priority if (xs < XW'(CMIN)) begin
      px_c = CMIN;
    end else if (xs > XW'(CMAX)) begin
      px_c = CMAX;
    end else begin
      px_c = xs[C-1:0];
    end
    priority if (ys < XW'(CMIN)) begin
      py_c = CMIN;
    end else if (ys > XW'(CMAX)) begin
      py_c = CMAX;
    end else begin
      py_c = ys[C-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else begin
      s8_v <= s7_v;
    end
    s8_px  <= px_c;
    s8_py  <= py_c;
    s8_tag <= s7_tag;
  end

  // stage 9: offset from the closest point to the centre
  logic                 s9_v;
  logic signed [DW-1:0] s9_ex, s9_ey;
  logic signed [C-1:0]  s9_px, s9_py;
  carry_t               s9_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else begin
      s9_v <= s8_v;
    end
    s9_ex  <= DW'(s8_tag.cx) - DW'(s8_px);
    s9_ey  <= DW'(s8_tag.cy) - DW'(s8_py);
    s9_px  <= s8_px;
    s9_py  <= s8_py;
    s9_tag <= s8_tag;
  end

  // stage 10: squared offset terms and absolute normal
  logic                  s10_v;
  logic signed [PRW-1:0] s10_ex2, s10_ey2;
  logic signed [DW-1:0]  s10_nx, s10_ny;
  logic signed [C-1:0]   s10_px, s10_py;
  carry_t                s10_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else begin
      s10_v <= s9_v;
    end
    s10_ex2 <= s9_ex * s9_ex;
    s10_ey2 <= s9_ey * s9_ey;
    s10_nx  <= s9_ex[DW-1] ? -s9_ex : s9_ex;
    s10_ny  <= s9_ey[DW-1] ? -s9_ey : s9_ey;
    s10_px  <= s9_px;
    s10_py  <= s9_py;
    s10_tag <= s9_tag;
  end

  // stage 11: final decision into the result registers
  logic signed [SW-1:0] e2;
  logic                 near;

  assign e2   = SW'(s10_ex2) + SW'(s10_ey2);
  assign near = (e2 <= $signed(SW'(s10_tag.r2)));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s10_v;
    end
    priority if (s10_tag.ep) begin
      // endpoint inside: normal from that endpoint, no closest point
      hit           <= 1'b1;
      normal_x      <= s10_tag.nxe;
      normal_y      <= s10_tag.nye;
      closest_valid <= 1'b0;
      closest_x     <= '0;
      closest_y     <= '0;
    end else if (s10_tag.proj) begin
      hit           <= s10_tag.t_rng && near;
      normal_x      <= s10_nx;
      normal_y      <= s10_ny;
      closest_valid <= 1'b1;
      closest_x     <= s10_px;
      closest_y     <= s10_py;
    end else begin
      // zero-length segment with both endpoints outside
      hit           <= 1'b0;
      normal_x      <= '0;
      normal_y      <= '0;
      closest_valid <= 1'b0;
      closest_x     <= '0;
      closest_y     <= '0;
    end
  end

endmodule

FILE: rtl/scc_div.sv
// pipelined restoring divider, one quotient bit per stage, with a tag carried along
// no package dependencies
module scc_div #(
  parameter int NUM_BITS = 50,
  parameter int DEN_BITS = 33,
  parameter int QUO_BITS = 35,
  parameter int TAG_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  input  logic [TAG_BITS-1:0] in_tag,
  output logic                out_valid,
  output logic [QUO_BITS-1:0] quo,
  output logic                sat,
  output logic [TAG_BITS-1:0] out_tag
);

  localparam int HI_BITS = NUM_BITS - QUO_BITS;

  logic [QUO_BITS:0]   v;
  logic [QUO_BITS:0]   sat_r;
  logic [QUO_BITS-1:0] q     [QUO_BITS+1];
  logic [TAG_BITS-1:0] tag   [QUO_BITS+1];
  logic [DEN_BITS-1:0] rem   [QUO_BITS];
  logic [QUO_BITS-1:0] low   [QUO_BITS];
  logic [DEN_BITS-1:0] den_r [QUO_BITS];

  logic [DEN_BITS-1:0] rem0;

  // upper numerator bits form the first partial remainder
  assign rem0 = {{(DEN_BITS-HI_BITS){1'b0}}, num[NUM_BITS-1:QUO_BITS]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
    sat_r[0] <= (rem0 >= den);
    q[0]     <= '0;
    tag[0]   <= in_tag;
    rem[0]   <= rem0;
    low[0]   <= num[QUO_BITS-1:0];
    den_r[0] <= den;
  end

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
    logic [DEN_BITS:0] trial;
    logic [DEN_BITS:0] diff;
    logic              ge;

    assign trial = {rem[i], low[i][QUO_BITS-1]};
    assign diff  = trial - {1'b0, den_r[i]};
    assign ge    = (trial >= {1'b0, den_r[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
      sat_r[i+1] <= sat_r[i];
      q[i+1]     <= {q[i][QUO_BITS-2:0], ge};
      tag[i+1]   <= tag[i];
    end

    if (i + 1 < QUO_BITS) begin : g_rem
      always_ff @(posedge clk) begin
        rem[i+1]   <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        low[i+1]   <= {low[i][QUO_BITS-2:0], 1'b0};
        den_r[i+1] <= den_r[i];
      end
    end
  end

  assign out_valid = v[QUO_BITS];
  assign quo       = q[QUO_BITS];
  assign sat       = sat_r[QUO_BITS];
  assign out_tag   = tag[QUO_BITS];

endmodule

FILE: rtl/scc_checker.sv
// port-level checks for segment_circle_collision, bound to the top level
// depends on segment_circle_collision_defines.svh
`include "segment_circle_collision_defines.svh"

module scc_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  busy,
  input logic                  done,
  input logic                  hit,
  input logic [COORD_BITS:0]   normal_x,
  input logic [COORD_BITS:0]   normal_y,
  input logic                  closest_valid,
  input logic [COORD_BITS-1:0] closest_x,
  input logic [COORD_BITS-1:0] closest_y
);

  `SCC_ASSERT_RST(a_rst_clears, !done)
  `SCC_ASSERT_IMP(a_proj_normal_pos, done && closest_valid, !normal_x[COORD_BITS] && !normal_y[COORD_BITS])
  `SCC_ASSERT_IMP(a_no_closest_zero, done && !closest_valid, closest_x == '0 && closest_y == '0)
  `SCC_ASSERT_IMP(a_degenerate_zero, done && !hit && !closest_valid, normal_x == '0 && normal_y == '0)
  `SCC_ASSERT_IMP(a_busy_reset_only, 1'b1, !busy)

endmodule

bind segment_circle_collision scc_checker #(
  .COORD_BITS (COORD_BITS)
) u_scc_checker (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .done          (done),
  .hit           (hit),
  .normal_x      (normal_x),
  .normal_y      (normal_y),
  .closest_valid (closest_valid),
  .closest_x     (closest_x),
  .closest_y     (closest_y)
);

FILE: tb/segment_circle_collision_checker.sv
// checker for segment_circle_collision: predicts each result from the accepted item and compares
// depends on scc_pkg for the coordinate and fraction widths
module segment_circle_collision_checker
  import scc_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic signed [SCC_COORD_BITS-1:0] center_x,
  input  logic signed [SCC_COORD_BITS-1:0] center_y,
  input  logic        [SCC_COORD_BITS-2:0] circle_radius,
  input  logic signed [SCC_COORD_BITS-1:0] start_x,
  input  logic signed [SCC_COORD_BITS-1:0] start_y,
  input  logic signed [SCC_COORD_BITS-1:0] end_x,
  input  logic signed [SCC_COORD_BITS-1:0] end_y,
  input  logic                             done,
  input  logic                             hit,
  input  logic signed [SCC_COORD_BITS:0]   normal_x,
  input  logic signed [SCC_COORD_BITS:0]   normal_y,
  input  logic                             closest_valid,
  input  logic signed [SCC_COORD_BITS-1:0] closest_x,
  input  logic signed [SCC_COORD_BITS-1:0] closest_y,
  output int                               errors,
  output int                               pending
);

  localparam int NBITS = SCC_COORD_BITS + 1;

  typedef struct packed {
    logic                             hit;
    logic signed [SCC_COORD_BITS:0]   nx;
    logic signed [SCC_COORD_BITS:0]   ny;
    logic                             cv;
    logic signed [SCC_COORD_BITS-1:0] px;
    logic signed [SCC_COORD_BITS-1:0] py;
  } contact_t;

  contact_t contacts_due[$];

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic contact_t collide(longint cx, longint cy, longint r, longint x1,
                                       longint y1, longint x2, longint y2);
    contact_t c;
    longint r2, ax, ay, bx, by, dx, dy, len2, dot, t, ex, ey, ppx, ppy;
    longint one, tlim, cmin, cmax;
    one  = longint'(1) <<< SCC_FRAC_BITS;
    tlim = longint'(1) <<< (SCC_FRAC_BITS + SCC_COORD_BITS + 2);
    cmin = -(longint'(1) <<< (SCC_COORD_BITS - 1));
    cmax = (longint'(1) <<< (SCC_COORD_BITS - 1)) - 1;
    c = '0;
    r2 = r * r;
    ax = cx - x1; ay = cy - y1;
    bx = cx - x2; by = cy - y2;
    if (ax * ax + ay * ay <= r2) begin
      c.hit = 1'b1; c.nx = NBITS'(ax); c.ny = NBITS'(ay);
    end else if (bx * bx + by * by <= r2) begin
      c.hit = 1'b1; c.nx = NBITS'(bx); c.ny = NBITS'(by);
    end else begin
      dx = x2 - x1; dy = y2 - y1;
      len2 = dx * dx + dy * dy;
      if (len2 != 0) begin
        dot = ax * dx + ay * dy;
        t = clip(round_div(dot * one, len2), -tlim, tlim);
        ppx = clip(x1 + round_div(t * dx, one), cmin, cmax);
        ppy = clip(y1 + round_div(t * dy, one), cmin, cmax);
        ex = cx - ppx; ey = cy - ppy;
        c.cv = 1'b1;
        c.px = SCC_COORD_BITS'(ppx); c.py = SCC_COORD_BITS'(ppy);
        c.nx = NBITS'((ex < 0) ? -ex : ex);
        c.ny = NBITS'((ey < 0) ? -ey : ey);
        c.hit = (dot >= 0 && dot <= len2 && ex * ex + ey * ey <= r2);
      end
    end
    return c;
  endfunction

  assign pending = contacts_due.size();

  initial errors = 0;

  always @(posedge clk) begin
    contact_t want;
    if (!rst) begin
      if (done) begin
        if (contacts_due.size() == 0) begin
          $display("%0t: unexpected result hit=%b", $time, hit);
          errors++;
        end else begin
          want = contacts_due.pop_front();
          if (want.hit !== hit) begin
            $display("%0t: hit expected %b actual %b", $time, want.hit, hit);
            errors++;
          end
          if (want.nx !== normal_x) begin
            $display("%0t: normal_x expected %0d actual %0d", $time, want.nx, normal_x);
            errors++;
          end
          if (want.ny !== normal_y) begin
            $display("%0t: normal_y expected %0d actual %0d", $time, want.ny, normal_y);
            errors++;
          end
          if (want.cv !== closest_valid) begin
            $display("%0t: closest_valid expected %b actual %b", $time, want.cv,
                     closest_valid);
            errors++;
          end
          if (want.px !== closest_x) begin
            $display("%0t: closest_x expected %0d actual %0d", $time, want.px, closest_x);
            errors++;
          end
          if (want.py !== closest_y) begin
            $display("%0t: closest_y expected %0d actual %0d", $time, want.py, closest_y);
            errors++;
          end
        end
      end
      if (start && !busy)
        contacts_due.push_back(collide(longint'(center_x), longint'(center_y),
                                       longint'(circle_radius), longint'(start_x),
                                       longint'(start_y), longint'(end_x),
                                       longint'(end_y)));
    end
  end

endmodule

FILE: tb/segment_circle_collision_tb.sv
// top of the segment_circle_collision testbench: clock, reset, stimulus and verdict
// depends on scc_pkg, the block and segment_circle_collision_checker
module segment_circle_collision_tb;
  import scc_pkg::*;

  localparam int MAX_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1440;
  localparam int DRAIN_CYCLES = 80;
  localparam int RBITS = SCC_COORD_BITS - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [SCC_COORD_BITS-1:0] center_x = '0, center_y = '0;
  logic        [SCC_COORD_BITS-2:0] circle_radius = '0;
  logic signed [SCC_COORD_BITS-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic done, hit, closest_valid;
  logic signed [SCC_COORD_BITS:0]   normal_x, normal_y;
  logic signed [SCC_COORD_BITS-1:0] closest_x, closest_y;
  int errors, pending;
  int cycles = 0;

  always #5 clk = ~clk;

  segment_circle_collision dut (.*);
  segment_circle_collision_checker checker_i (.*);

  // hard stop in case the block never answers
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // present one item at the falling edge, hold it until accepted, then idle for gap cycles
  task automatic send_pair(int cx, int cy, int r, int x1, int y1, int x2, int y2, int gap);
    @(negedge clk);
    center_x <= SCC_COORD_BITS'(cx); center_y <= SCC_COORD_BITS'(cy);
    circle_radius <= RBITS'(r);
    start_x <= SCC_COORD_BITS'(x1); start_y <= SCC_COORD_BITS'(y1);
    end_x <= SCC_COORD_BITS'(x2); end_y <= SCC_COORD_BITS'(y2);
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // coordinate near a point, kept inside the signed range
  function automatic int near(int base, int span);
    int v;
    v = base + $signed($urandom_range(2 * span)) - span;
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  initial begin
    int cx, cy, r, span, x1, y1, x2, y2, kind;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes and the special cases
    send_pair(0, 0, 160, 16, 16, 3200, 3200, 0);          // first endpoint inside
    send_pair(0, 0, 160, 3200, 3200, 16, -16, 0);         // second endpoint inside
    send_pair(0, 0, 160, 160, 0, 0, 160, 0);              // both on the circle, first wins
    send_pair(0, 0, 0, 0, 0, 50, 50, 0);                  // zero radius on an endpoint
    send_pair(100, 100, 16, 500, 500, 500, 500, 0);       // zero-length segment, miss
    send_pair(0, 50, 60, -1000, 0, 1000, 0, 1);           // projection hit in the middle
    send_pair(0, 50, 40, -1000, 0, 1000, 0, 0);           // projection inside, too far
    send_pair(5000, 10, 100, -1000, 0, 1000, 0, 3);       // projection beyond the end
    send_pair(-5000, 10, 100, -1000, 0, 1000, 0, 0);      // projection before the start
    send_pair(32767, -32768, 0, 32767, 32751, 32751, 32767, 0); // closest point saturates
    send_pair(-32768, -32768, 32767, 32767, 32767, 32767, -32768, 0);
    send_pair(32767, 32767, 32767, -32768, -32768, -32768, 32767, 2);
    send_pair(-32768, 32767, 0, 32767, -32768, -32768, 32767, 0);
    send_pair(32767, 32767, 0, -32768, -32768, 32767, -32768, 0);
    send_pair(0, 0, 32767, -32768, -32768, -32768, -32768, 0);
    send_pair(-32768, -32768, 1, -32768, -32767, 32767, 32767, 0);
    send_pair(-21846, 21845, 5461, 0, 0, -1, -1, 0);
    send_pair(1, 2, 3, 4, 5, 6, 7, 0);
    send_pair(0, 160, 160, -16, 0, 16, 0, 0);             // tangent to the segment

    // let the pipeline empty before the random part
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(9);
      if (kind < 3) begin
        // anything the ports allow
        cx = $signed(16'($urandom)); cy = $signed(16'($urandom));
        r = $urandom_range(32767);
        x1 = $signed(16'($urandom)); y1 = $signed(16'($urandom));
        x2 = $signed(16'($urandom)); y2 = $signed(16'($urandom));
      end else begin
        // geometry close to the circle so that every path is taken often
        cx = $signed(16'($urandom)); cy = $signed(16'($urandom));
        r = (kind == 9) ? $urandom_range(32767) : $urandom_range(2000);
        span = 2 * r + 32;
        x1 = near(cx, span); y1 = near(cy, span);
        if (kind == 8) begin
          x2 = x1; y2 = y1;
        end else begin
          x2 = near(cx, span); y2 = near(cy, span);
        end
      end
      send_pair(cx, cy, r, x1, y1, x2, y2,
                ($urandom_range(3) == 0) ? 0 : $urandom_range(9));
      if (i % 400 == 399) begin
        // stretch of back-to-back items
        repeat (30) send_pair(near(0, 4000), near(0, 4000), $urandom_range(3000),
                              near(0, 4000), near(0, 4000), near(0, 4000), near(0, 4000), 0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
